// File: src/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types, opcodes and command/status bundles for the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   // opcodes of the request transaction
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef logic signed [31:0] word_type;

   typedef struct packed {
      logic [1:0] opcode;
      word_type   push_value;
      logic [4:0] position;
   } req_type;

   typedef struct packed {
      word_type   read_value;
      logic       read_valid;
      logic       push_dropped;
      logic [5:0] entry_count;
      logic       full_flag;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic xfer_rd;
      logic exec;
      logic push_wr;
      logic drop;
      logic pop_rd;
      logic peek_out_rd;
      logic peek_in_rd;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       in_full;
      logic       in_empty;
      logic       out_empty;
      logic       hit_out;
      logic       hit_in;
      logic       xfer_pend;
      logic       rsp_free;
   } status_type;

endpackage

// File: src/two_stack_queue_core.sv
// ----------------------------------------------------------------------------
// two_stack_queue_core
// FIFO of signed 32-bit words built from an input stack and an output stack.
// ----------------------------------------------------------------------------
// Each request transaction (push, pop front, peek at a queue position) gives
// exactly one response transaction carrying the read word, its valid flag, a
// dropped-push flag, the total entry count and the full flag. Both stacks are
// single-port-write memories of STACK_DEPTH words; a push lands on the input
// stack and a pop leaves from the output stack. When a pop finds the output
// stack empty, or a push finds the input stack full with the output stack
// empty, the whole input stack is first copied over, one word per cycle
// through the memory read register. One transaction is in work at a time:
// a plain item steps through accept, execute and loading of the response
// register, which waits while the previous response is stalled. An item
// that triggers the copy adds the execute step that starts the copy, a read
// for each word moved, the last write and a settle step before executing
// again. Each word is copied at most once. A finished response sits in its
// own register, so the next request is taken while the previous response
// is still stalled.
// ----------------------------------------------------------------------------
module two_stack_queue_core
   import tsq_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: accept, optional stack copy, execute, hand off response
   tsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // stacks, depth counters and response register
   tsq_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: src/tsq_ctrl.sv
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer: accepts a request, runs the stack transfer when needed, issues
// the operation and hands the result to the response register.
// ----------------------------------------------------------------------------
module tsq_ctrl
   import tsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_XFER,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (status.opcode)
               OP_PUSH: begin
                  if (status.in_full && status.out_empty) begin
                     state_in = S_XFER;
                  end else begin
                     cmd.exec    = 1'b1;
                     cmd.push_wr = !status.in_full;
                     cmd.drop    = status.in_full;
                  end
               end
               OP_POP: begin
                  if (status.out_empty && !status.in_empty) begin
                     state_in = S_XFER;
                  end else begin
                     cmd.exec   = 1'b1;
                     cmd.pop_rd = !status.out_empty;
                  end
               end
               OP_PEEK: begin
                  cmd.exec        = 1'b1;
                  cmd.peek_out_rd = status.hit_out;
                  cmd.peek_in_rd  = !status.hit_out && status.hit_in;
               end
               default: begin
                  cmd.exec = 1'b1;
               end
            endcase
         end
         S_XFER: begin
            // read side runs until the input stack is empty, write side follows in the cycle after each read
            cmd.xfer_rd = !status.in_empty;
            if (status.in_empty && !status.xfer_pend) begin
               state_in = S_EXEC;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/tsq_datapath.sv
// ----------------------------------------------------------------------------
// tsq_datapath
// Two stack memories, their depth counters, request latch and the response
// register.
// ----------------------------------------------------------------------------
module tsq_datapath
   import tsq_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   output rsp_type    rsp_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CMP_W   = ((DEPTH_W > 5) ? DEPTH_W : 5) + 1;
   localparam int SUM_W   = ((DEPTH_W + 1) > 6) ? (DEPTH_W + 1) : 6;

   word_type in_mem  [STACK_DEPTH];
   word_type out_mem [STACK_DEPTH];

   logic [1:0]         op_ff;
   word_type           val_ff;
   logic [4:0]         pos_ff;
   logic [DEPTH_W-1:0] in_depth_ff;
   logic [DEPTH_W-1:0] out_depth_ff;
   logic               xfer_pend_ff;
   word_type           in_rd_ff;
   word_type           out_rd_ff;
   logic               valid_ff;
   logic               drop_ff;
   logic               sel_in_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  od_x;
   logic [CMP_W-1:0]  id_x;
   logic [CMP_W-1:0]  diff;
   logic [CMP_W-1:0]  out_peek;
   logic [ADDR_W-1:0] in_raddr;
   logic [ADDR_W-1:0] out_raddr;
   logic [SUM_W-1:0]  sum;
   logic              in_full;
   logic              out_empty;
   rsp_type           rsp_in;

   assign pos_x    = CMP_W'(pos_ff);
   assign od_x     = CMP_W'(out_depth_ff);
   assign id_x     = CMP_W'(in_depth_ff);
   assign diff     = pos_x - od_x;
   assign out_peek = od_x - CMP_W'(1) - pos_x;

   assign in_full   = (in_depth_ff == DEPTH_W'(STACK_DEPTH));
   assign out_empty = (out_depth_ff == '0);

   assign in_raddr  = cmd.xfer_rd ? ADDR_W'(in_depth_ff - DEPTH_W'(1)) : diff[ADDR_W-1:0];
   assign out_raddr = cmd.pop_rd ? ADDR_W'(out_depth_ff - DEPTH_W'(1))
                                 : out_peek[ADDR_W-1:0];

   assign status.opcode    = op_ff;
   assign status.in_full   = in_full;
   assign status.in_empty  = (in_depth_ff == '0);
   assign status.out_empty = out_empty;
   assign status.hit_out   = (pos_x < od_x);
   assign status.hit_in    = (pos_x >= od_x) && (diff < id_x);
   assign status.xfer_pend = xfer_pend_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign sum = SUM_W'(in_depth_ff) + SUM_W'(out_depth_ff);

   always_comb begin
      rsp_in              = '0;
      rsp_in.read_valid   = valid_ff;
      rsp_in.push_dropped = drop_ff;
      rsp_in.entry_count  = sum[5:0];
      rsp_in.full_flag    = in_full && !out_empty;
      if (valid_ff) begin
         rsp_in.read_value = sel_in_ff ? in_rd_ff : out_rd_ff;
      end
   end

   // stack memories
   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         in_mem[in_depth_ff[ADDR_W-1:0]] <= val_ff;
      end
      if (cmd.xfer_rd || cmd.peek_in_rd) begin
         in_rd_ff <= in_mem[in_raddr];
      end
      if (xfer_pend_ff) begin
         out_mem[out_depth_ff[ADDR_W-1:0]] <= in_rd_ff;
      end
      if (cmd.pop_rd || cmd.peek_out_rd) begin
         out_rd_ff <= out_mem[out_raddr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_data.opcode;
         val_ff <= req_data.push_value;
         pos_ff <= req_data.position;
      end
      if (cmd.exec) begin
         valid_ff  <= cmd.pop_rd || cmd.peek_out_rd || cmd.peek_in_rd;
         drop_ff   <= cmd.drop;
         sel_in_ff <= cmd.peek_in_rd;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_depth_ff  <= '0;
         out_depth_ff <= '0;
         xfer_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         xfer_pend_ff <= cmd.xfer_rd;
         if (cmd.xfer_rd) begin
            in_depth_ff <= in_depth_ff - DEPTH_W'(1);
         end else if (cmd.push_wr) begin
            in_depth_ff <= in_depth_ff + DEPTH_W'(1);
         end
         if (xfer_pend_ff) begin
            out_depth_ff <= out_depth_ff + DEPTH_W'(1);
         end else if (cmd.pop_rd) begin
            out_depth_ff <= out_depth_ff - DEPTH_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/tsq_checker.sv
// ----------------------------------------------------------------------------
// tsq_checker
// Port-level checks on the two-stack queue, bound to the top level.
// ----------------------------------------------------------------------------
module tsq_checker
   import tsq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // one request transaction in work at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a dropped push leaves the queue full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.push_dropped |-> rsp_data.full_flag)
      else $error("push dropped while not full");

   // no read data without a valid read
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.read_valid |-> rsp_data.read_value == '0)
      else $error("read value not zero on invalid read");

   // a push never reads and a read never drops
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.read_valid && rsp_data.push_dropped))
      else $error("read valid and push dropped together");

endmodule

bind two_stack_queue_core tsq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
